// ===== rtl/rwg_pkg.sv =====
// Package for the ramp waveform generator: default widths, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rwg_pkg;

  // Default widths
  localparam int AMP_BITS_DEF  = 12;
  localparam int TICK_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE_SELECT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEP        = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_LIMIT       = 2'd2;

  // The one valid amplitude besides full scale
  localparam int EIGHT_BIT_MAX = 255;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // take the input item, update prescaler and ramp
    logic start_div1;  // start maxv / step
    logic mul;         // register normmax and numerator
    logic start_div2;  // check and start numerator / normmax
    logic load_out;    // load the output register
  } rwg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;    // divider idle, quotient valid
    logic skip;        // second divide not needed (zero or saturated)
  } rwg_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rwg_div.sv =====
// Restoring divider, one quotient bit per cycle, AMP_BITS iterations.
// Needs dividend high half below divisor. Uses rwg_pkg.
`default_nettype none

module rwg_div import rwg_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [AMP_BITS-1:0] dividend_hi,
  input  wire logic [AMP_BITS-1:0] dividend_lo,
  input  wire logic [AMP_BITS-1:0] divisor,
  output logic                     done,
  output logic [AMP_BITS-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(AMP_BITS + 1);

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [AMP_BITS-1:0] rem_r, rem_nxt;
  logic [AMP_BITS-1:0] quo_r, quo_nxt;
  logic [AMP_BITS-1:0] div_r, div_nxt;
  logic [AMP_BITS:0]   shifted;
  logic [AMP_BITS:0]   diff;

  // Trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[AMP_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    if (start) begin
      cnt_nxt = CNT_BITS'(AMP_BITS);
      rem_nxt = dividend_hi;
      quo_nxt = dividend_lo;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[AMP_BITS]) begin
        rem_nxt = diff[AMP_BITS-1:0];
        quo_nxt = {quo_r[AMP_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[AMP_BITS-1:0];
        quo_nxt = {quo_r[AMP_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = (cnt_r == '0);
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/rwg_dpath.sv =====
// Datapath: configuration registers, prescaler, ramp counter, normalizer
// multiplies and the output register. Uses rwg_pkg and rwg_div.
`default_nettype none

module rwg_dpath import rwg_pkg::*; #(
  parameter int AMP_BITS  = AMP_BITS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF,
  parameter int CFG_BITS  = (AMP_BITS > TICK_BITS) ? AMP_BITS : TICK_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  input  wire logic                    in_advance,
  input  wire rwg_cmd_t                cmd,
  output rwg_sts_t                     sts,
  output logic [AMP_BITS-1:0]          out_norm_amplitude,
  output logic                         out_prescaler_wrapped,
  output logic                         out_ramp_wrapped,
  output logic                         out_config_error
);

  localparam logic [AMP_BITS-1:0] AMP_MASK = {AMP_BITS{1'b1}};

  logic [AMP_BITS-1:0]    amp_r, amp_nxt;
  logic [AMP_BITS-1:0]    step_r, step_nxt;
  logic [TICK_BITS-1:0]   limit_r, limit_nxt;
  logic [TICK_BITS:0]     pre_r, pre_nxt;
  logic [AMP_BITS-1:0]    ramp_r, ramp_nxt;
  logic                   pw_r, pw_nxt;
  logic                   rw_r, rw_nxt;
  logic [AMP_BITS-1:0]    normmax_r, normmax_nxt;
  logic [2*AMP_BITS-1:0]  numer_r, numer_nxt;
  logic                   zero_r, zero_nxt;
  logic                   sat_r, sat_nxt;
  logic [AMP_BITS-1:0]    norm_r, norm_nxt;
  logic                   opw_r, opw_nxt;
  logic                   orw_r, orw_nxt;
  logic                   err_r, err_nxt;

  logic                   bad_amp;
  logic [AMP_BITS-1:0]    maxv;
  logic [AMP_BITS-1:0]    step_wr;
  logic [TICK_BITS:0]     pre_inc;
  logic [AMP_BITS:0]      ramp_sum;
  logic [2*AMP_BITS-1:0]  nm_prod;
  logic                   zero_now;
  logic                   sat_now;
  logic                   div_start;
  logic [AMP_BITS-1:0]    div_hi;
  logic [AMP_BITS-1:0]    div_lo;
  logic [AMP_BITS-1:0]    div_den;
  logic                   div_done;
  logic [AMP_BITS-1:0]    div_quo;

  // Effective maximum from the amplitude setting
  always_comb begin
    if (amp_r == AMP_BITS'(EIGHT_BIT_MAX) || amp_r == AMP_MASK) begin
      bad_amp = 1'b0;
      maxv    = amp_r;
    end else begin
      bad_amp = 1'b1;
      maxv    = AMP_BITS'(1);
    end
  end

  // Configuration writes; drop a step of zero or full scale
  assign step_wr = cfg_data[AMP_BITS-1:0];

  always_comb begin
    amp_nxt   = amp_r;
    step_nxt  = step_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMPLITUDE_SELECT: amp_nxt = cfg_data[AMP_BITS-1:0];
        CFG_RAMP_STEP: begin
          if (step_wr != '0 && step_wr != AMP_MASK) step_nxt = step_wr;
        end
        CFG_TICK_LIMIT: limit_nxt = cfg_data[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance prescaler and ramp on a tick
  assign pre_inc  = pre_r + 1'b1;
  assign ramp_sum = {1'b0, ramp_r} + {1'b0, step_r};

  always_comb begin
    pre_nxt  = pre_r;
    ramp_nxt = ramp_r;
    pw_nxt   = pw_r;
    rw_nxt   = rw_r;
    if (cmd.accept) begin
      pw_nxt = 1'b0;
      rw_nxt = 1'b0;
      if (in_advance) begin
        if (pre_inc > {1'b0, limit_r}) begin
          pre_nxt = '0;
          pw_nxt  = 1'b1;
          if (ramp_sum > {1'b0, maxv}) begin
            ramp_nxt = '0;
            rw_nxt   = 1'b1;
          end else begin
            ramp_nxt = ramp_sum[AMP_BITS-1:0];
          end
        end else begin
          pre_nxt = pre_inc;
        end
      end
    end
  end

  // Normalizer and numerator products
  assign nm_prod = step_r * div_quo;

  always_comb begin
    normmax_nxt = normmax_r;
    numer_nxt   = numer_r;
    if (cmd.mul) begin
      normmax_nxt = nm_prod[AMP_BITS-1:0];
      numer_nxt   = ramp_r * maxv;
    end
  end

  // Special cases of the second divide
  assign zero_now = (normmax_r == '0);
  assign sat_now  = (numer_r[2*AMP_BITS-1:AMP_BITS] >= normmax_r);

  always_comb begin
    zero_nxt = zero_r;
    sat_nxt  = sat_r;
    if (cmd.start_div2) begin
      zero_nxt = zero_now;
      sat_nxt  = sat_now;
    end
  end

  // Shared divider: maxv / step, then numerator / normmax
  assign div_start = cmd.start_div1 | (cmd.start_div2 & ~zero_now & ~sat_now);
  assign div_hi    = cmd.start_div1 ? '0 : numer_r[2*AMP_BITS-1:AMP_BITS];
  assign div_lo    = cmd.start_div1 ? maxv : numer_r[AMP_BITS-1:0];
  assign div_den   = cmd.start_div1 ? step_r : normmax_r;

  rwg_div #(
    .AMP_BITS (AMP_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_den),
    .done        (div_done),
    .quotient    (div_quo)
  );

  assign sts.div_done = div_done;
  assign sts.skip     = zero_now | sat_now;

  // Output register
  always_comb begin
    norm_nxt = norm_r;
    opw_nxt  = opw_r;
    orw_nxt  = orw_r;
    err_nxt  = err_r;
    if (cmd.load_out) begin
      priority if (zero_r) norm_nxt = '0;
      else if (sat_r)      norm_nxt = AMP_MASK;
      else                 norm_nxt = div_quo;
      opw_nxt = pw_r;
      orw_nxt = rw_r;
      err_nxt = bad_amp | zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= AMP_MASK;
      step_r  <= AMP_BITS'(1);
      limit_r <= '0;
      pre_r   <= '0;
      ramp_r  <= '0;
    end else begin
      amp_r   <= amp_nxt;
      step_r  <= step_nxt;
      limit_r <= limit_nxt;
      pre_r   <= pre_nxt;
      ramp_r  <= ramp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r      <= pw_nxt;
    rw_r      <= rw_nxt;
    normmax_r <= normmax_nxt;
    numer_r   <= numer_nxt;
    zero_r    <= zero_nxt;
    sat_r     <= sat_nxt;
    norm_r    <= norm_nxt;
    opw_r     <= opw_nxt;
    orw_r     <= orw_nxt;
    err_r     <= err_nxt;
  end

  assign out_norm_amplitude    = norm_r;
  assign out_prescaler_wrapped = opw_r;
  assign out_ramp_wrapped      = orw_r;
  assign out_config_error      = err_r;

endmodule

`default_nettype wire

// ===== rtl/rwg_ctrl.sv =====
// Controller: sequences accept, divide, multiply, optional second
// divide and output load, owns in_stall and out_valid. Uses rwg_pkg.
`default_nettype none

module rwg_ctrl import rwg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire rwg_sts_t sts,
  output rwg_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = ~ovalid_r | ~out_stall;

  // Step through the item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.start_div1 = 1'b1;
          state_nxt      = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (sts.div_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.start_div2 = 1'b1;
        state_nxt      = sts.skip ? ST_OUT : ST_DIV2;
      end
      ST_DIV2: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until the transfer
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.load_out)               ovalid_nxt = 1'b1;
    else if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule

`default_nettype wire

// ===== rtl/ramp_waveform_generator_unit.sv =====
// Ramp waveform generator: sawtooth with tick prescaler and normalization.
// Each input item passes accept, the first divide, multiply, check, the second
// divide (skipped on a zero normalizer or saturated quotient) and output load.
// A new item is taken only after the last is loaded, as both divides share the
// bit-serial divider; a stalled output holds the load and so the next item.
// Synchronous active-low reset: amplitude full scale, step 1, counts zero.
`default_nettype none

module ramp_waveform_generator_unit import rwg_pkg::*; #(
  parameter int AMP_BITS  = AMP_BITS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_advance,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [AMP_BITS-1:0]          out_norm_amplitude,
  output logic                         out_prescaler_wrapped,
  output logic                         out_ramp_wrapped,
  output logic                         out_config_error,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [((AMP_BITS > TICK_BITS) ? AMP_BITS : TICK_BITS)-1:0] cfg_data
);

  localparam int CFG_BITS = (AMP_BITS > TICK_BITS) ? AMP_BITS : TICK_BITS;

  rwg_cmd_t cmd;
  rwg_sts_t sts;

  // Writes are taken at any time
  assign cfg_ready = 1'b1;

  rwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwg_dpath #(
    .AMP_BITS  (AMP_BITS),
    .TICK_BITS (TICK_BITS),
    .CFG_BITS  (CFG_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_valid & cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_advance            (in_advance),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_norm_amplitude    (out_norm_amplitude),
    .out_prescaler_wrapped (out_prescaler_wrapped),
    .out_ramp_wrapped      (out_ramp_wrapped),
    .out_config_error      (out_config_error)
  );

endmodule

`default_nettype wire

// ===== sim/ramp_waveform_generator_unit_test.sv =====
// Self-checking bench for ramp_waveform_generator_unit: directed and random ticks
// under several amplitude, step and prescaler settings, with random stalls.
// Depends on rwg_pkg and the RTL of the ramp waveform generator.
module ramp_waveform_generator_unit_test;
  import rwg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AMP_W   = AMP_BITS_DEF;
  localparam int TICK_W  = TICK_BITS_DEF;
  localparam int CFG_W   = (AMP_W > TICK_W) ? AMP_W : TICK_W;
  localparam int MAX_CYCLES   = 1000000;
  localparam int MAX_REPORTED = 10;
  localparam int SEGMENTS     = 12;
  localparam int SEG_TICKS    = 161;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [AMP_W-1:0] AMP_FULL  = '1;
  localparam logic [AMP_W-1:0] AMP_EIGHT = AMP_W'(EIGHT_BIT_MAX);

  typedef struct packed {
    logic [AMP_W-1:0] norm_amplitude;
    logic             prescaler_wrapped;
    logic             ramp_wrapped;
    logic             config_error;
  } ramp_sample_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_advance = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  wire logic in_stall;
  wire logic out_valid;
  wire logic [AMP_W-1:0] out_norm_amplitude;
  wire logic out_prescaler_wrapped;
  wire logic out_ramp_wrapped;
  wire logic out_config_error;
  wire logic cfg_ready;

  // Mirror of the generator state and its registers
  logic [TICK_W:0]   gen_prescale;
  logic [AMP_W-1:0]  gen_ramp;
  logic [AMP_W-1:0]  gen_amp_sel;
  logic [AMP_W-1:0]  gen_step;
  logic [TICK_W-1:0] gen_tick_limit;

  logic         tick_q[$];
  ramp_sample_t sample_expect_q[$];
  int           n_queued = 0;
  int           n_accepted = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         in_taken = 1'b0;

  ramp_waveform_generator_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_advance            (in_advance),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_norm_amplitude    (out_norm_amplitude),
    .out_prescaler_wrapped (out_prescaler_wrapped),
    .out_ramp_wrapped      (out_ramp_wrapped),
    .out_config_error      (out_config_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one register write to the mirrored configuration
  function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    case (idx)
      CFG_AMPLITUDE_SELECT: gen_amp_sel = data[AMP_W-1:0];
      CFG_RAMP_STEP: begin
        // drop a zero step or one at full scale
        if (data[AMP_W-1:0] != '0 && data[AMP_W-1:0] != AMP_FULL)
          gen_step = data[AMP_W-1:0];
      end
      CFG_TICK_LIMIT: gen_tick_limit = data[TICK_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the mirrored generator by one tick item and return its sample
  function automatic ramp_sample_t next_ramp_sample(input logic adv);
    ramp_sample_t s;
    logic [AMP_W-1:0]   maxv;
    logic [AMP_W:0]     sum;
    logic [2*AMP_W-1:0] normmax;
    logic [2*AMP_W-1:0] quot;
    s = '0;
    if (gen_amp_sel == AMP_EIGHT || gen_amp_sel == AMP_FULL) begin
      maxv = gen_amp_sel;
    end else begin
      maxv = AMP_W'(1);
      s.config_error = 1'b1;
    end
    if (adv) begin
      gen_prescale = gen_prescale + 1'b1;
      if (gen_prescale > {1'b0, gen_tick_limit}) begin
        s.prescaler_wrapped = 1'b1;
        gen_prescale = '0;
        sum = {1'b0, gen_ramp} + {1'b0, gen_step};
        if (sum > {1'b0, maxv}) begin
          sum = '0;
          s.ramp_wrapped = 1'b1;
        end
        gen_ramp = sum[AMP_W-1:0];
      end
    end
    normmax = (gen_step == '0) ? '0 : gen_step * (maxv / gen_step);
    if (normmax == '0) begin
      s.config_error = 1'b1;
    end else begin
      quot = (gen_ramp * maxv) / normmax;
      s.norm_amplitude = (quot > AMP_FULL) ? AMP_FULL : quot[AMP_W-1:0];
    end
    return s;
  endfunction

  // Drive the tick channel from the pending queue, stall results at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_advance <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_advance <= 1'($urandom_range(1));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Track register writes, predict on each tick transfer, check each result transfer
  always @(posedge clk) begin
    ramp_sample_t got;
    ramp_sample_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      gen_prescale = '0;
      gen_ramp = '0;
      gen_amp_sel = AMP_FULL;
      gen_step = AMP_W'(1);
      gen_tick_limit = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_norm_amplitude, out_prescaler_wrapped, out_ramp_wrapped,
                out_config_error};
        if (sample_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("%0t: result with nothing pending: amp=%0d pre=%0b ramp=%0b err=%0b",
                     $realtime, got.norm_amplitude, got.prescaler_wrapped,
                     got.ramp_wrapped, got.config_error);
        end else begin
          want = sample_expect_q.pop_front();
          if (got.norm_amplitude !== want.norm_amplitude
              || got.prescaler_wrapped !== want.prescaler_wrapped
              || got.ramp_wrapped !== want.ramp_wrapped
              || got.config_error !== want.config_error) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
              $display("%0t: mismatch: expected amp=%0d pre=%0b ramp=%0b err=%0b, got amp=%0d pre=%0b ramp=%0b err=%0b",
                       $realtime, want.norm_amplitude, want.prescaler_wrapped,
                       want.ramp_wrapped, want.config_error, got.norm_amplitude,
                       got.prescaler_wrapped, got.ramp_wrapped, got.config_error);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        sample_expect_q.push_back(next_ramp_sample(in_advance));
        n_accepted++;
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Write one register through the configuration channel
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued tick is taken and every sample has come back
  task automatic drain();
    do @(negedge clk); while (n_accepted != n_queued || sample_expect_q.size() != 0);
  endtask

  // Queue n ticks, bit i of pattern being the advance of tick i, then drain
  task automatic play(input logic [15:0] pattern, input int n);
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      tick_q.push_back(pattern[i]);
      n_queued++;
    end
    drain();
  endtask

  initial begin
    logic [AMP_W-1:0]  amp_val;
    logic [AMP_W-1:0]  step_val;
    logic [TICK_W-1:0] tick_val;
    int pick;

    send_idle_pct = 22;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: step 1, prescaler wraps every tick, plus read-only ticks
    play(16'b11011, 5);
    // Ignored step writes and a write to the unused index
    write_reg(CFG_RAMP_STEP, 16'h0000);
    write_reg(CFG_RAMP_STEP, 16'h0fff);
    write_reg(CFG_UNUSED_IDX, 16'hffff);
    play(16'b01, 2);
    // Large step pushes the quotient past full scale
    write_reg(CFG_RAMP_STEP, 16'h0fa0);
    play(16'b1, 1);
    // Switch to 8-bit amplitude with the ramp still high, upper data bits ignored
    write_reg(CFG_RAMP_STEP, 16'hf0c8);
    write_reg(CFG_AMPLITUDE_SELECT, 16'h00ff);
    play(16'b10, 2);
    // Step above the maximum leaves a zero normalizer
    write_reg(CFG_RAMP_STEP, 16'h012c);
    play(16'b01, 2);
    // Invalid amplitude settings fall back to a maximum of one
    write_reg(CFG_AMPLITUDE_SELECT, 16'h0064);
    write_reg(CFG_RAMP_STEP, 16'h0001);
    play(16'b11, 2);
    write_reg(CFG_AMPLITUDE_SELECT, 16'h0000);
    play(16'b0, 1);
    // Widest prescaler, then a short one
    write_reg(CFG_AMPLITUDE_SELECT, 16'hffff);
    write_reg(CFG_TICK_LIMIT, 16'hffff);
    play(16'b111, 3);
    write_reg(CFG_TICK_LIMIT, 16'h0002);
    play(16'b11, 2);
    write_reg(CFG_TICK_LIMIT, 16'h0000);
    play(16'b1, 1);

    // Random segments, each under a fresh setting, written while idle
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 61;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick = $urandom_range(9);
      if (pick < 4) amp_val = AMP_EIGHT;
      else if (pick < 8) amp_val = AMP_FULL;
      else amp_val = AMP_W'($urandom_range(0, 4095));

      pick = $urandom_range(9);
      if (pick < 5) step_val = AMP_W'($urandom_range(1, 8));
      else if (pick < 7) step_val = AMP_W'($urandom_range(9, 300));
      else if (pick < 8) step_val = AMP_W'(4094);
      else step_val = AMP_W'($urandom_range(0, 4095));

      pick = $urandom_range(9);
      if (pick < 6) tick_val = TICK_W'($urandom_range(0, 3));
      else if (pick < 8) tick_val = TICK_W'($urandom_range(4, 20));
      else tick_val = TICK_W'($urandom_range(0, 65535));

      write_reg(CFG_AMPLITUDE_SELECT, {4'($urandom_range(15)), amp_val});
      write_reg(CFG_RAMP_STEP, {4'($urandom_range(15)), step_val});
      write_reg(CFG_TICK_LIMIT, tick_val);
      if ($urandom_range(3) == 0)
        write_reg(CFG_UNUSED_IDX, CFG_W'($urandom_range(0, 65535)));

      @(posedge clk);
      for (int i = 0; i < SEG_TICKS; i++) begin
        tick_q.push_back($urandom_range(9) < 8);
        n_queued++;
      end
      drain();
    end

    // Let any stray result surface before judging
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && sample_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== ramp_waveform_generator_unit.f =====
rtl/rwg_pkg.sv
rtl/rwg_div.sv
rtl/rwg_dpath.sv
rtl/rwg_ctrl.sv
rtl/ramp_waveform_generator_unit.sv
sim/ramp_waveform_generator_unit_test.sv
